FILE: design/bap_pkg.sv
// shared types and constants of the block average pixelate unit
// no dependencies; used by every module of the block by scoped names
package bap_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_REGION = 64;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 11;
  localparam int OFS_W   = 6;
  localparam int SIZE_W  = 7;
  localparam int DIM_W   = 12;
  localparam int CNT_W   = 13;
  // a region holds at most 64 x 64 pixels of 255: 20 bits per channel
  localparam int SUM_W   = 20;
  // one accumulator entry: three channel sums
  localparam int ACC_W   = 3 * SUM_W;
  localparam int STEP_W  = 5;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam logic [SIZE_W-1:0] MAX_REGION_C = SIZE_W'(MAX_REGION);
  localparam logic [DIM_W-1:0]  MAX_WIDTH_C  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]  MAX_HEIGHT_C = DIM_W'(MAX_HEIGHT);

  typedef enum logic [1:0] {
    CFG_REGION_SIZE  = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_t;

  // one classified pixel, front to back
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
    logic [OFS_W-1:0] ofs_x;
    logic [OFS_W-1:0] ofs_y;
    logic             first;
    logic             last;
    logic             frame_done;
  } pix_word_t;

  // region tag carried alongside the division
  typedef struct packed {
    logic [COL_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CNT_W-1:0] pixels;
    logic             frame_done;
  } reg_tag_t;

endpackage

FILE: design/bap_front.sv
// front end: config registers, raster position counters, pixel classification
// depends on bap_pkg
module bap_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [bap_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bap_pkg::PIX_W-1:0]     in_red_in,
  input  logic [bap_pkg::PIX_W-1:0]     in_green_in,
  input  logic [bap_pkg::PIX_W-1:0]     in_blue_in,
  input  logic                          q_full,
  output logic                          q_push,
  output bap_pkg::pix_word_t            q_word
);

  logic [bap_pkg::SIZE_W-1:0] size_r;
  logic [bap_pkg::DIM_W-1:0]  width_r, height_r;
  logic [bap_pkg::COL_W-1:0]  px_r, py_r, rx_r, ry_r;
  logic [bap_pkg::OFS_W-1:0]  ox_r, oy_r;
  logic [bap_pkg::COL_W-1:0]  px_nxt, py_nxt, rx_nxt, ry_nxt;
  logic [bap_pkg::OFS_W-1:0]  ox_nxt, oy_nxt;
  logic [bap_pkg::SIZE_W-1:0] size_c;
  logic [bap_pkg::DIM_W-1:0]  width_c, height_c;
  logic row_end, frame_end, edge_x, edge_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= bap_pkg::SIZE_W'(8);
      width_r  <= bap_pkg::DIM_W'(640);
      height_r <= bap_pkg::DIM_W'(480);
    end else if (cfg_valid) begin
      case (cfg_index)
        bap_pkg::CFG_REGION_SIZE:  size_r   <= cfg_data[bap_pkg::SIZE_W-1:0];
        bap_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_data;
        bap_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    size_c   = (size_r == '0) ? bap_pkg::SIZE_W'(1) :
               (size_r > bap_pkg::MAX_REGION_C) ? bap_pkg::MAX_REGION_C : size_r;
    width_c  = (width_r == '0) ? bap_pkg::DIM_W'(1) :
               (width_r > bap_pkg::MAX_WIDTH_C) ? bap_pkg::MAX_WIDTH_C : width_r;
    height_c = (height_r == '0) ? bap_pkg::DIM_W'(1) :
               (height_r > bap_pkg::MAX_HEIGHT_C) ? bap_pkg::MAX_HEIGHT_C : height_r;
  end

  assign row_end   = ({1'b0, px_r} + bap_pkg::DIM_W'(1)) >= width_c;
  assign frame_end = ({1'b0, py_r} + bap_pkg::DIM_W'(1)) >= height_c;
  assign edge_x    = ({1'b0, ox_r} + bap_pkg::SIZE_W'(1)) >= size_c;
  assign edge_y    = ({1'b0, oy_r} + bap_pkg::SIZE_W'(1)) >= size_c;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_word.red        = in_red_in;
    q_word.green      = in_green_in;
    q_word.blue       = in_blue_in;
    q_word.col        = rx_r;
    q_word.row        = ry_r;
    q_word.ofs_x      = ox_r;
    q_word.ofs_y      = oy_r;
    q_word.first      = (ox_r == '0) && (oy_r == '0);
    q_word.last       = (row_end || edge_x) && (frame_end || edge_y);
    q_word.frame_done = row_end && frame_end;
  end

  always_comb begin
    px_nxt = px_r;
    py_nxt = py_r;
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    rx_nxt = rx_r;
    ry_nxt = ry_r;
    if (row_end) begin
      px_nxt = '0;
      ox_nxt = '0;
      rx_nxt = '0;
      if (frame_end) begin
        py_nxt = '0;
        oy_nxt = '0;
        ry_nxt = '0;
      end else begin
        py_nxt = py_r + 1'b1;
        if (edge_y) begin
          oy_nxt = '0;
          ry_nxt = ry_r + 1'b1;
        end else begin
          oy_nxt = oy_r + 1'b1;
        end
      end
    end else begin
      px_nxt = px_r + 1'b1;
      if (edge_x) begin
        ox_nxt = '0;
        rx_nxt = rx_r + 1'b1;
      end else begin
        ox_nxt = ox_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      ox_r <= '0;
      oy_r <= '0;
      rx_r <= '0;
      ry_r <= '0;
    end else if (q_push) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
    end
  end

endmodule

FILE: design/bap_fifo.sv
// short word queue between front and back
// depends on bap_pkg
module bap_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bap_pkg::pix_word_t push_word,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output bap_pkg::pix_word_t head_word
);

  bap_pkg::pix_word_t slot_r [bap_pkg::QDEPTH];
  logic [bap_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [bap_pkg::QCNT_W-1:0] cnt_r;
  logic do_pop;

  assign full      = cnt_r == bap_pkg::QCNT_W'(bap_pkg::QDEPTH);
  assign not_empty = cnt_r != '0;
  assign head_word = slot_r[rp_r];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + bap_pkg::QCNT_W'(push) - bap_pkg::QCNT_W'(do_pop);
    end
  end

endmodule

FILE: design/bap_div.sv
// iterative divider for the three channel sums, one quotient bit per cycle
// depends on bap_pkg
module bap_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bap_pkg::SUM_W-1:0]   sum_red,
  input  logic [bap_pkg::SUM_W-1:0]   sum_green,
  input  logic [bap_pkg::SUM_W-1:0]   sum_blue,
  input  bap_pkg::reg_tag_t           tag_in,
  output logic                        busy,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [bap_pkg::PIX_W-1:0]   avg_red,
  output logic [bap_pkg::PIX_W-1:0]   avg_green,
  output logic [bap_pkg::PIX_W-1:0]   avg_blue,
  output bap_pkg::reg_tag_t           tag_out
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } div_st_t;

  div_st_t st_r, st_nxt;
  logic [bap_pkg::SUM_W-1:0]  dvd_r [3];
  logic [bap_pkg::CNT_W-1:0]  rem_r [3];
  logic [bap_pkg::SUM_W-1:0]  dvd_nxt [3];
  logic [bap_pkg::CNT_W-1:0]  rem_nxt [3];
  logic [bap_pkg::CNT_W:0]    trial [3];
  logic [bap_pkg::STEP_W-1:0] step_r;
  bap_pkg::reg_tag_t          tag_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_r[c], dvd_r[c][bap_pkg::SUM_W-1]};
      if (trial[c] >= {1'b0, tag_r.pixels}) begin
        rem_nxt[c] = bap_pkg::CNT_W'(trial[c] - {1'b0, tag_r.pixels});
        dvd_nxt[c] = {dvd_r[c][bap_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[c] = trial[c][bap_pkg::CNT_W-1:0];
        dvd_nxt[c] = {dvd_r[c][bap_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (start) st_nxt = ST_RUN;
      ST_RUN:  if (step_r == bap_pkg::STEP_W'(bap_pkg::SUM_W - 1)) st_nxt = ST_DONE;
      ST_DONE: if (res_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      step_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_RUN) step_r <= step_r + 1'b1;
      else step_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && start) begin
      dvd_r[0] <= sum_red;
      dvd_r[1] <= sum_green;
      dvd_r[2] <= sum_blue;
      for (int c = 0; c < 3; c++) rem_r[c] <= '0;
      tag_r <= tag_in;
    end else if (st_r == ST_RUN) begin
      for (int c = 0; c < 3; c++) begin
        dvd_r[c] <= dvd_nxt[c];
        rem_r[c] <= rem_nxt[c];
      end
    end
  end

  assign busy      = st_r != ST_IDLE;
  assign res_valid = st_r == ST_DONE;
  assign avg_red   = dvd_r[0][bap_pkg::PIX_W-1:0];
  assign avg_green = dvd_r[1][bap_pkg::PIX_W-1:0];
  assign avg_blue  = dvd_r[2][bap_pkg::PIX_W-1:0];
  assign tag_out   = tag_r;

endmodule

FILE: design/bap_back.sv
// back end: column accumulator memory with read-modify-write and the divider
// depends on bap_pkg, bap_div
module bap_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_not_empty,
  input  bap_pkg::pix_word_t          q_head,
  output logic                        q_pop,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [bap_pkg::PIX_W-1:0]   avg_red,
  output logic [bap_pkg::PIX_W-1:0]   avg_green,
  output logic [bap_pkg::PIX_W-1:0]   avg_blue,
  output bap_pkg::reg_tag_t           tag_out
);

  logic [bap_pkg::ACC_W-1:0] mem [bap_pkg::MAX_WIDTH];
  logic [bap_pkg::ACC_W-1:0] rd_r, last_sum_r, base, sum;
  bap_pkg::pix_word_t s1_r;
  logic s1_v_r, fwd_r;
  logic s1_go, take, div_start, div_busy;
  logic [2*(bap_pkg::OFS_W+1)-1:0] count_full;
  bap_pkg::reg_tag_t tag;

  assign s1_go     = s1_v_r && (!s1_r.last || !div_busy);
  assign take      = q_not_empty && (!s1_v_r || s1_go);
  assign q_pop     = take;
  assign div_start = s1_go && s1_r.last;

  // registered read; hold while the stage stalls
  always_ff @(posedge clk) begin
    if (take) rd_r <= mem[q_head.col];
    if (s1_go) mem[s1_r.col] <= sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else if (take) begin
      s1_v_r <= 1'b1;
      // older word writes the same entry in this cycle: read is stale
      fwd_r  <= s1_v_r && (s1_r.col == q_head.col);
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) s1_r <= q_head;
    if (s1_go) last_sum_r <= sum;
  end

  always_comb begin
    if (s1_r.first) base = '0;
    else if (fwd_r) base = last_sum_r;
    else base = rd_r;
    sum = {base[3*bap_pkg::SUM_W-1:2*bap_pkg::SUM_W] + bap_pkg::SUM_W'(s1_r.red),
           base[2*bap_pkg::SUM_W-1:bap_pkg::SUM_W]   + bap_pkg::SUM_W'(s1_r.green),
           base[bap_pkg::SUM_W-1:0]                  + bap_pkg::SUM_W'(s1_r.blue)};
  end

  assign count_full = ({1'b0, s1_r.ofs_x} + 1'b1) * ({1'b0, s1_r.ofs_y} + 1'b1);

  always_comb begin
    tag.row        = s1_r.row;
    tag.col        = s1_r.col;
    tag.pixels     = count_full[bap_pkg::CNT_W-1:0];
    tag.frame_done = s1_r.frame_done;
  end

  bap_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .sum_red   (sum[3*bap_pkg::SUM_W-1:2*bap_pkg::SUM_W]),
    .sum_green (sum[2*bap_pkg::SUM_W-1:bap_pkg::SUM_W]),
    .sum_blue  (sum[bap_pkg::SUM_W-1:0]),
    .tag_in    (tag),
    .busy      (div_busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .avg_red   (avg_red),
    .avg_green (avg_green),
    .avg_blue  (avg_blue),
    .tag_out   (tag_out)
  );

  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");
  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_v_r) else $error("forward flag without a word in stage");
  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (!s1_v_r || s1_go)) else $error("stage overwritten");
  a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> tag_out.pixels != '0) else $error("zero region pixel count");

endmodule

FILE: design/block_average_pixelate_unit.sv
// block average pixelate unit, top level
// depends on bap_pkg, bap_front, bap_fifo, bap_back (with bap_div)
//
// Pixels come in raster order, one word per accepted in_ handshake, and the
// frame is tiled into square regions of region_size pixels (smaller at the
// right and bottom edges). Channel sums are kept per region column in a
// 2048-entry accumulator memory; on the last pixel of a region the unit
// delivers the truncated channel averages, the region row and column, the
// pixel count and a frame_done flag on the out_ channel. Pixels are taken
// one per clock unless a finished region waits for the divider; each
// finished region goes through a shared iterative divider that loads the
// sums, works out one quotient bit per cycle for the 20-bit sums and holds
// the result until it is taken, so a finished region holds the pixel
// pipeline while the divider is still busy with the previous one. A
// four-word queue between the position counters and the accumulator lets
// the input keep flowing while the back end waits. Accumulator entries hold
// nothing useful until the first pixel of a region writes them, so no
// clearing pass runs after reset. Configuration writes take effect at once
// and should be made only while the unit is idle; cfg_ready is always high.
module block_average_pixelate_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [bap_pkg::DIM_W-1:0]      cfg_data,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bap_pkg::PIX_W-1:0]      in_red_in,
  input  logic [bap_pkg::PIX_W-1:0]      in_green_in,
  input  logic [bap_pkg::PIX_W-1:0]      in_blue_in,
  // region results
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bap_pkg::PIX_W-1:0]      out_red_avg,
  output logic [bap_pkg::PIX_W-1:0]      out_green_avg,
  output logic [bap_pkg::PIX_W-1:0]      out_blue_avg,
  output logic [bap_pkg::COL_W-1:0]      out_region_row,
  output logic [bap_pkg::COL_W-1:0]      out_region_col,
  output logic [bap_pkg::CNT_W-1:0]      out_region_pixels,
  output logic                           out_frame_done
);

  // front to queue
  logic               q_full, q_push;
  bap_pkg::pix_word_t q_word;
  // queue to back
  logic               q_pop, q_not_empty;
  bap_pkg::pix_word_t q_head;
  bap_pkg::reg_tag_t  tag;

  // position counters and region classification
  bap_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_red_in   (in_red_in),
    .in_green_in (in_green_in),
    .in_blue_in  (in_blue_in),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_word      (q_word)
  );

  // decouples pixel intake from accumulate and divide
  bap_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_word),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_word (q_head)
  );

  // accumulate per region column, divide on region end
  bap_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .res_valid   (out_valid),
    .res_ready   (out_ready),
    .avg_red     (out_red_avg),
    .avg_green   (out_green_avg),
    .avg_blue    (out_blue_avg),
    .tag_out     (tag)
  );

  assign out_region_row    = tag.row;
  assign out_region_col    = tag.col;
  assign out_region_pixels = tag.pixels;
  assign out_frame_done    = tag.frame_done;

endmodule
